FILE: hw/rtl/pbrd_pkg.sv
// Shared constants for the pixel-budget resize block: field widths,
// register indexes and reset values. No dependencies.
package pbrd_pkg;

    localparam int DIM_BITS_DEF  = 14;
    localparam int F_BITS        = 8;
    localparam int PX_BITS       = 28;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 28;

    localparam int unsigned MAX_ASPECT = 200;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ALIGN_FACTOR = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_PIXELS   = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_PIXELS   = 2'd2;

    localparam logic [F_BITS-1:0]  ALIGN_FACTOR_RST = 8'd28;
    localparam logic [PX_BITS-1:0] MIN_PIXELS_RST   = 28'd3136;
    localparam logic [PX_BITS-1:0] MAX_PIXELS_RST   = 28'd12845056;

endpackage

FILE: hw/rtl/pbrd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Generic widths, no package dependency.
module pbrd_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0] trial;
    logic           fits;

    always_comb begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0)
        else $error("divider idle with nonzero step count");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == CNT_W'(1) && !start |=> !busy_reg)
        else $error("divider did not finish after last step");

endmodule

FILE: hw/rtl/pbrd_sqrt.sv
// Bit-serial integer square root (floor), one root bit per cycle from two
// radicand bits. Generic width, no package dependency.
module pbrd_sqrt #(
    parameter int IN_W  = 16,
    parameter int PAIRS = (IN_W + 1) / 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IN_W-1:0]  radicand,
    output logic             busy,
    output logic [PAIRS-1:0] root
);

    localparam int CNT_W = $clog2(PAIRS + 1);

    logic [2*PAIRS-1:0] rad_reg;
    logic [PAIRS-1:0]   root_reg;
    logic [PAIRS+1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;

    logic [PAIRS+1:0] cur;
    logic [PAIRS+1:0] trial;
    logic             fits;

    // remainder stays at most twice the root, so PAIRS+2 bits hold it
    always_comb begin
        cur   = {rem_reg[PAIRS-1:0], rad_reg[2*PAIRS-1 -: 2]};
        trial = {root_reg, 2'b01};
        fits  = cur >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(PAIRS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= (2*PAIRS)'(radicand);
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*PAIRS-3:0], 2'b00};
            root_reg <= {root_reg[PAIRS-2:0], fits};
            rem_reg  <= fits ? (cur - trial) : cur;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0)
        else $error("square root idle with nonzero step count");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg <= {root_reg, 1'b0})
        else $error("square root remainder above twice the root");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == CNT_W'(PAIRS))
        else $error("square root did not load on start");

endmodule

FILE: hw/rtl/pixel_budget_resize_dims_core.sv
// Pixel-budget resize: maps an image height/width to sides that are multiples of
// align_factor with a product inside [min_pixel_count, max_pixel_count].
// Depends on pbrd_pkg, pbrd_div and pbrd_sqrt.
//
// One image at a time. A zero side or an aspect above 200 returns zero sides with
// status 1 straight from the check state, with no divide. When the rounded product
// is in budget the result follows the bit-serial rounding divide by the factor.
// When the budget must be enforced, a bit-serial divide over DIM_BITS+28 bits and
// a bit-serial square root over (DIM_BITS+29)/2 steps follow. s_tready is high
// while no image is in work; a finished result waits in the output register and
// the next image may be taken meanwhile. Configuration writes take effect at once
// and belong in idle periods.
module pixel_budget_resize_dims_core #(
    parameter int DIM_BITS = pbrd_pkg::DIM_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration
    input  logic                                    cfg_wr_en,
    input  logic [pbrd_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
    input  logic [pbrd_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // fields from bit 0: in_height, in_width
    input  logic [((2*DIM_BITS+7)/8)*8-1:0]         s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // fields from bit 0: out_height, out_width
    output logic [((2*(DIM_BITS+1)+7)/8)*8-1:0]     m_tdata,
    // fields from bit 0: status
    output logic [0:0]                              m_tuser
);

    import pbrd_pkg::*;

    localparam int OUT_W   = DIM_BITS + 1;
    localparam int MD_W    = ((2*OUT_W + 7) / 8) * 8;
    localparam int ASP_W   = DIM_BITS + 8;
    localparam int PROD_W  = 2 * OUT_W;
    localparam int CMP_W   = (PROD_W > PX_BITS) ? PROD_W : PX_BITS;
    localparam int FF_W    = 2 * F_BITS;
    localparam int T_W     = DIM_BITS + PX_BITS;
    localparam int D_W     = DIM_BITS + FF_W;
    localparam int N_W     = (T_W + 1) / 2;
    localparam int S_W     = N_W + 1 + F_BITS;
    localparam logic [OUT_W-1:0] OUT_MASK = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RDIV,
        ST_ROUND,
        ST_SCALE,
        ST_PROD,
        ST_CMP,
        ST_MUL1,
        ST_MUL2,
        ST_BLOAD,
        ST_BDIV,
        ST_SQRT,
        ST_SIDE,
        ST_SAT,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [F_BITS-1:0]  align_reg;
    logic [PX_BITS-1:0] min_reg;
    logic [PX_BITS-1:0] max_reg;

    logic [DIM_BITS-1:0] h_reg, w_reg;
    logic [F_BITS-1:0]   f_reg;
    logic                grow_reg;
    logic [OUT_W-1:0]    qh_reg, qw_reg, hb_reg, wb_reg, cap_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [T_W-1:0]      th_reg, tw_reg;
    logic [FF_W-1:0]     ff_reg;
    logic [D_W-1:0]      dh_reg, dw_reg;
    logic [S_W-1:0]      sh_reg, sw_reg;
    logic [OUT_W-1:0]    res_h_reg, res_w_reg;
    logic                res_st_reg;
    logic [OUT_W-1:0]    out_h_reg, out_w_reg;
    logic                out_st_reg;
    logic                m_tvalid_reg;

    // rounding stage units
    logic              rdiv_start;
    logic              rh_busy, rw_busy, rc_busy;
    logic [OUT_W-1:0]  rh_q, rw_q, rc_q;
    logic [F_BITS-1:0] rh_r, rw_r, rc_r;
    // budget stage units
    logic              bdiv_start, sqrt_start;
    logic              bh_busy, bw_busy, sh_busy, sw_busy;
    logic [T_W-1:0]    bh_q, bw_q;
    logic [D_W-1:0]    bh_r, bw_r;
    logic [N_W-1:0]    root_h, root_w;

    logic [DIM_BITS-1:0] lo, hi;
    logic [ASP_W-1:0]    aspect_lim;
    logic                bad_dims;
    logic                up_h, up_w;
    logic [PX_BITS-1:0]  px;
    logic                out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg <= ALIGN_FACTOR_RST;
            min_reg   <= MIN_PIXELS_RST;
            max_reg   <= MAX_PIXELS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ALIGN_FACTOR: align_reg <= cfg_wdata[F_BITS-1:0];
                REG_MIN_PIXELS:   min_reg   <= cfg_wdata[PX_BITS-1:0];
                REG_MAX_PIXELS:   max_reg   <= cfg_wdata[PX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        lo         = (h_reg < w_reg) ? h_reg : w_reg;
        hi         = (h_reg < w_reg) ? w_reg : h_reg;
        aspect_lim = ASP_W'(MAX_ASPECT) * ASP_W'(lo);
        bad_dims   = (lo == '0) || (ASP_W'(hi) > aspect_lim);
        // nearest multiple, ties to the even quotient
        up_h = ({rh_r, 1'b0} > {1'b0, f_reg}) || (({rh_r, 1'b0} == {1'b0, f_reg}) && rh_q[0]);
        up_w = ({rw_r, 1'b0} > {1'b0, f_reg}) || (({rw_r, 1'b0} == {1'b0, f_reg}) && rw_q[0]);
        px   = grow_reg ? min_reg : max_reg;
    end

    assign rdiv_start = (state_reg == ST_CHECK) && !bad_dims;
    assign bdiv_start = (state_reg == ST_BLOAD);
    assign sqrt_start = (state_reg == ST_BDIV) && !bh_busy && !bw_busy;
    assign out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        h_reg     <= s_tdata[DIM_BITS-1:0];
                        w_reg     <= s_tdata[2*DIM_BITS-1:DIM_BITS];
                        f_reg     <= (align_reg == '0) ? F_BITS'(1) : align_reg;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (bad_dims) begin
                        res_h_reg  <= '0;
                        res_w_reg  <= '0;
                        res_st_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_RDIV;
                    end
                end
                ST_RDIV: begin
                    if (!rh_busy && !rw_busy && !rc_busy) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    qh_reg    <= rh_q + OUT_W'(up_h);
                    qw_reg    <= rw_q + OUT_W'(up_w);
                    // largest multiple of the factor that fits the output field
                    cap_reg   <= OUT_MASK - OUT_W'(rc_r);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    hb_reg    <= qh_reg * OUT_W'(f_reg);
                    wb_reg    <= qw_reg * OUT_W'(f_reg);
                    state_reg <= ST_PROD;
                end
                ST_PROD: begin
                    prod_reg  <= PROD_W'(hb_reg) * PROD_W'(wb_reg);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (CMP_W'(prod_reg) > CMP_W'(max_reg)) begin
                        grow_reg  <= 1'b0;
                        state_reg <= ST_MUL1;
                    end else if (CMP_W'(prod_reg) < CMP_W'(min_reg)) begin
                        grow_reg  <= 1'b1;
                        state_reg <= ST_MUL1;
                    end else begin
                        res_h_reg  <= hb_reg;
                        res_w_reg  <= wb_reg;
                        res_st_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_MUL1: begin
                    th_reg    <= T_W'(h_reg) * T_W'(px);
                    tw_reg    <= T_W'(w_reg) * T_W'(px);
                    ff_reg    <= FF_W'(f_reg) * FF_W'(f_reg);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    dh_reg    <= D_W'(w_reg) * D_W'(ff_reg);
                    dw_reg    <= D_W'(h_reg) * D_W'(ff_reg);
                    // ceiling search as floor search on t-1, plus one
                    th_reg    <= th_reg - T_W'(grow_reg);
                    tw_reg    <= tw_reg - T_W'(grow_reg);
                    state_reg <= ST_BLOAD;
                end
                ST_BLOAD: begin
                    state_reg <= ST_BDIV;
                end
                ST_BDIV: begin
                    if (!bh_busy && !bw_busy) begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (!sh_busy && !sw_busy) begin
                        state_reg <= ST_SIDE;
                    end
                end
                ST_SIDE: begin
                    sh_reg    <= (S_W'(root_h) + S_W'(grow_reg)) * S_W'(f_reg);
                    sw_reg    <= (S_W'(root_w) + S_W'(grow_reg)) * S_W'(f_reg);
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    res_h_reg  <= (sh_reg > S_W'(OUT_MASK)) ? cap_reg : sh_reg[OUT_W-1:0];
                    res_w_reg  <= (sw_reg > S_W'(OUT_MASK)) ? cap_reg : sw_reg[OUT_W-1:0];
                    res_st_reg <= 1'b0;
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_h_reg    <= res_h_reg;
                        out_w_reg    <= res_w_reg;
                        out_st_reg   <= res_st_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    pbrd_div #(.NUM_W(OUT_W), .DEN_W(F_BITS)) u_rdiv_h (
        .aclk(aclk), .aresetn(aresetn), .start(rdiv_start),
        .dividend(OUT_W'(h_reg)), .divisor(f_reg),
        .busy(rh_busy), .quotient(rh_q), .remainder(rh_r)
    );

    pbrd_div #(.NUM_W(OUT_W), .DEN_W(F_BITS)) u_rdiv_w (
        .aclk(aclk), .aresetn(aresetn), .start(rdiv_start),
        .dividend(OUT_W'(w_reg)), .divisor(f_reg),
        .busy(rw_busy), .quotient(rw_q), .remainder(rw_r)
    );

    // output-field limit modulo the factor, for saturation
    pbrd_div #(.NUM_W(OUT_W), .DEN_W(F_BITS)) u_rdiv_cap (
        .aclk(aclk), .aresetn(aresetn), .start(rdiv_start),
        .dividend(OUT_MASK), .divisor(f_reg),
        .busy(rc_busy), .quotient(rc_q), .remainder(rc_r)
    );

    pbrd_div #(.NUM_W(T_W), .DEN_W(D_W)) u_bdiv_h (
        .aclk(aclk), .aresetn(aresetn), .start(bdiv_start),
        .dividend(th_reg), .divisor(dh_reg),
        .busy(bh_busy), .quotient(bh_q), .remainder(bh_r)
    );

    pbrd_div #(.NUM_W(T_W), .DEN_W(D_W)) u_bdiv_w (
        .aclk(aclk), .aresetn(aresetn), .start(bdiv_start),
        .dividend(tw_reg), .divisor(dw_reg),
        .busy(bw_busy), .quotient(bw_q), .remainder(bw_r)
    );

    pbrd_sqrt #(.IN_W(T_W), .PAIRS(N_W)) u_sqrt_h (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(bh_q), .busy(sh_busy), .root(root_h)
    );

    pbrd_sqrt #(.IN_W(T_W), .PAIRS(N_W)) u_sqrt_w (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(bw_q), .busy(sw_busy), .root(root_w)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MD_W'({out_w_reg, out_h_reg});
    assign m_tuser  = out_st_reg;

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_CHECK)
        else $error("input transfer did not start the checks");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finish state");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_st_reg |-> out_h_reg == '0 && out_w_reg == '0)
        else $error("error result with nonzero sides");

    a_rdiv_free: assert property (@(posedge aclk) disable iff (!aresetn)
        rdiv_start |-> !rh_busy && !rw_busy && !rc_busy)
        else $error("rounding divider restarted while busy");

    a_budget_free: assert property (@(posedge aclk) disable iff (!aresetn)
        bdiv_start |-> !bh_busy && !bw_busy && !sh_busy && !sw_busy)
        else $error("budget units restarted while busy");

    // budget remainders below their divisors, cap equal to the factor multiple
    a_div_results: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQRT |-> bh_r < dh_reg && bw_r < dw_reg &&
            cap_reg == OUT_W'(rc_q * OUT_W'(f_reg)))
        else $error("divider results inconsistent");

endmodule
